### design/rwss_pkg.sv
`default_nettype none
package rwss_pkg;

  localparam int PWM_W  = 10;
  localparam int DIST_W = 12;
  localparam int CFG_DW = 12;
  localparam int LOST_W = 8;

  // ramp step and lost-target limit
  localparam int RAMP_STEP  = 5;
  localparam int LOST_TICKS = 20;
  localparam int LOST_HOLD  = 200;

  localparam logic [PWM_W-1:0]  PWM_LOW_RST    = 10'd480;
  localparam logic [PWM_W-1:0]  PWM_MID_RST    = 10'd550;
  localparam logic [PWM_W-1:0]  PWM_HIGH_RST   = 10'd650;
  localparam logic [PWM_W-1:0]  PWM_MAX_RST    = 10'd730;
  localparam logic [PWM_W-1:0]  PWM_SENTRY_RST = 10'd730;
  localparam logic [DIST_W-1:0] NEAR_CM_RST    = 12'd120;
  localparam logic [DIST_W-1:0] FAR_CM_RST     = 12'd300;

  // serial multiply over the distance bits, restoring divide over the quotient bits
  localparam int MUL_STEPS = DIST_W;
  localparam int DIV_STEPS = PWM_W;

  typedef enum logic [2:0] {
    REG_PWM_LOW    = 3'd0,
    REG_PWM_MID    = 3'd1,
    REG_PWM_HIGH   = 3'd2,
    REG_PWM_MAX    = 3'd3,
    REG_PWM_SENTRY = 3'd4,
    REG_NEAR_CM    = 3'd5,
    REG_FAR_CM     = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] SW_NOT_DOWN = 2'd0;
  localparam logic [1:0] SW_DOWN     = 2'd1;
  localparam logic [1:0] SW_DOWN_UP  = 2'd2;

endpackage
`default_nettype wire

### design/rwss_cmd_if.sv
`default_nettype none
interface rwss_cmd_if;
  import rwss_pkg::*;

  logic              valid;
  logic              ready;
  logic              starting;
  logic              remote_mode;
  logic [1:0]        switch_pos;
  logic              buff_hit;
  logic              mouse_left;
  logic              auto_aim;
  logic              key_low;
  logic              key_mid;
  logic              target_seen;
  logic              aim_sentry;
  logic [DIST_W-1:0] distance_cm;
  logic              magazine_open;

  modport source (
    output valid, starting, remote_mode, switch_pos, buff_hit, mouse_left, auto_aim,
           key_low, key_mid, target_seen, aim_sentry, distance_cm, magazine_open,
    input  ready
  );

  modport sink (
    input  valid, starting, remote_mode, switch_pos, buff_hit, mouse_left, auto_aim,
           key_low, key_mid, target_seen, aim_sentry, distance_cm, magazine_open,
    output ready
  );
endinterface
`default_nettype wire

### design/rwss_rsp_if.sv
`default_nettype none
interface rwss_rsp_if;
  import rwss_pkg::*;

  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] pwm_out;
  logic             beam_en;
  logic [PWM_W-1:0] speed_target;
  logic             wheel_armed;

  modport source (
    output valid, pwm_out, beam_en, speed_target, wheel_armed,
    input  ready
  );

  modport sink (
    input  valid, pwm_out, beam_en, speed_target, wheel_armed,
    output ready
  );
endinterface
`default_nettype wire

### design/ramped_wheel_speed_selector_top.sv
// A request is latched, then an auto-aim range interpolation, when it runs, does a serial
//   multiply and a serial divide before the update; the update and result are registered.
// A new request is taken only once the previous one is finished, and the update waits
//   for the output register to be free; multiply and divide share one bit-serial datapath.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, high) loads the register defaults and clears all tick state.
`default_nettype none
module ramped_wheel_speed_selector_top #(
  parameter int RAMP_STEP  = rwss_pkg::RAMP_STEP,
  parameter int LOST_TICKS = rwss_pkg::LOST_TICKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire rwss_pkg::cfg_idx_t            cfg_addr,
  input  wire logic [rwss_pkg::CFG_DW-1:0]   cfg_wdata,
  rwss_cmd_if.sink                           cmd,
  rwss_rsp_if.source                         rsp
);
  import rwss_pkg::*;

  localparam int WORK_W = PWM_W + 1 + DIST_W;
  localparam int CNT_W  = $clog2(MUL_STEPS);
  localparam logic [PWM_W-1:0]  STEP_V   = PWM_W'(RAMP_STEP);
  localparam logic [PWM_W:0]    STEP_X   = (PWM_W+1)'(RAMP_STEP);
  localparam logic [LOST_W-1:0] LOST_LIM = LOST_W'(LOST_TICKS);
  localparam logic [LOST_W-1:0] LOST_HLD = LOST_W'(LOST_HOLD);
  localparam logic [LOST_W-1:0] LOST_TOP = {LOST_W{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;
  typedef enum logic [1:0] {SWS_OFF, SWS_ARMED, SWS_TOGGLE} sw_step_t;

  // configuration
  logic [PWM_W-1:0]  pwm_low, pwm_mid, pwm_high, pwm_max, pwm_sentry;
  logic [DIST_W-1:0] near_cm, far_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_low    <= PWM_LOW_RST;
      pwm_mid    <= PWM_MID_RST;
      pwm_high   <= PWM_HIGH_RST;
      pwm_max    <= PWM_MAX_RST;
      pwm_sentry <= PWM_SENTRY_RST;
      near_cm    <= NEAR_CM_RST;
      far_cm     <= FAR_CM_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_PWM_LOW:    pwm_low    <= cfg_wdata[PWM_W-1:0];
        REG_PWM_MID:    pwm_mid    <= cfg_wdata[PWM_W-1:0];
        REG_PWM_HIGH:   pwm_high   <= cfg_wdata[PWM_W-1:0];
        REG_PWM_MAX:    pwm_max    <= cfg_wdata[PWM_W-1:0];
        REG_PWM_SENTRY: pwm_sentry <= cfg_wdata[PWM_W-1:0];
        REG_NEAR_CM:    near_cm    <= cfg_wdata[DIST_W-1:0];
        REG_FAR_CM:     far_cm     <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // control and tick state
  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [WORK_W-1:0] work;
  logic              neg;
  sw_step_t          sw_step;
  logic [PWM_W-1:0]  target_pwm, level_pwm, real_pwm;
  logic [LOST_W-1:0] lost_count;
  logic              out_valid;
  logic [PWM_W-1:0]  out_pwm, out_target;
  logic              out_laser, out_armed;

  // latched request
  logic       r_starting, r_remote, r_buff, r_mouse, r_aim, r_klow, r_kmid;
  logic       r_seen, r_sentry, r_mag;
  logic [1:0] r_sw;

  logic accept, fin_fire, far_above;
  assign accept    = cmd.valid && cmd.ready;
  assign fin_fire  = (state == S_FIN) && (!out_valid || rsp.ready);
  assign far_above = far_cm > near_cm;

  // set-up at request: clamped distance offset and magnitude of the PWM span
  logic [DIST_W-1:0] dist_cl, dist_off;
  logic [PWM_W-1:0]  span_mag, span_mag_q;
  logic              span_neg, interp_req;

  always_comb begin
    if (cmd.distance_cm < near_cm) begin
      dist_cl = near_cm;
    end else if (cmd.distance_cm > far_cm) begin
      dist_cl = far_cm;
    end else begin
      dist_cl = cmd.distance_cm;
    end
    dist_off = dist_cl - near_cm;
    span_neg = pwm_high < pwm_low;
    span_mag = span_neg ? (pwm_low - pwm_high) : (pwm_high - pwm_low);
    interp_req = !cmd.starting && !cmd.remote_mode && !cmd.buff_hit &&
                 !(cmd.mouse_left && !cmd.auto_aim) && !cmd.key_low && !cmd.key_mid &&
                 cmd.auto_aim && cmd.target_seen && far_above;
  end

  // one shift-add or one restoring-divide step per cycle
  logic [PWM_W+1:0]  mul_sum;
  logic [DIST_W:0]   div_rem, div_diff;
  logic [DIST_W-1:0] span_dist;
  logic              div_ok;
  logic [WORK_W-1:0] mul_next, div_next;

  always_comb begin
    span_dist = far_cm - near_cm;
    mul_sum   = {1'b0, work[WORK_W-1:DIST_W]} + {2'b00, span_mag_q};
    if (work[0]) begin
      mul_next = {mul_sum, work[DIST_W-1:1]};
    end else begin
      mul_next = {1'b0, work[WORK_W-1:DIST_W], work[DIST_W-1:1]};
    end
    div_rem  = {work[WORK_W-2:PWM_W], work[PWM_W-1]};
    div_diff = div_rem - {1'b0, span_dist};
    div_ok   = div_rem >= {1'b0, span_dist};
    div_next = {1'b0, (div_ok ? div_diff[DIST_W-1:0] : div_rem[DIST_W-1:0]),
                work[PWM_W-2:0], div_ok};
  end

  // tick update
  logic [PWM_W-1:0]  interp_val, quot;
  sw_step_t          sw_step_next;
  logic [PWM_W-1:0]  target_next, level_next, real_next;
  logic [LOST_W-1:0] lost_next, lost_inc;
  logic [PWM_W:0]    ramp_up;

  always_comb begin
    quot = work[PWM_W-1:0];
    if (!far_above) begin
      interp_val = pwm_high;
    end else if (neg) begin
      interp_val = pwm_low - quot;
    end else begin
      interp_val = pwm_low + quot;
    end

    sw_step_next = sw_step;
    target_next  = target_pwm;
    level_next   = level_pwm;
    lost_next    = lost_count;
    lost_inc     = (lost_count == LOST_TOP) ? LOST_TOP : lost_count + 1'b1;
    real_next    = real_pwm;

    if (r_starting) begin
      target_next = '0;
      real_next   = '0;
    end else if (r_remote) begin
      case (r_sw)
        SW_DOWN_UP: begin
          if (sw_step == SWS_ARMED) begin
            sw_step_next = SWS_TOGGLE;
          end else if (sw_step == SWS_TOGGLE) begin
            sw_step_next = SWS_OFF;
          end
        end
        SW_DOWN: sw_step_next = SWS_ARMED;
        default: sw_step_next = SWS_OFF;
      endcase
      if (sw_step_next == SWS_TOGGLE) begin
        target_next = (target_pwm != '0) ? '0 : pwm_low;
      end else if (target_pwm > pwm_low) begin
        target_next = pwm_low;
      end
    end else begin
      if (r_buff) begin
        level_next = pwm_max;
      end else if (r_mouse && !r_aim) begin
        level_next = pwm_high;
      end else if (r_klow) begin
        level_next = pwm_low;
      end else if (r_kmid) begin
        level_next = pwm_mid;
      end else if (r_aim) begin
        if (r_seen) begin
          lost_next  = '0;
          level_next = interp_val;
        end else if (lost_inc >= LOST_LIM) begin
          lost_next  = LOST_HLD;
          level_next = pwm_high;
        end else begin
          lost_next = lost_inc;
        end
        if (r_sentry) begin
          level_next = pwm_sentry;
        end
      end else begin
        level_next = pwm_high;
      end
      if (r_mouse || target_pwm != '0) begin
        target_next = level_next;
      end
    end

    // ramp toward the target; downward steps may undershoot, floor at zero
    ramp_up = {1'b0, real_next} + STEP_X;
    if (real_next < target_next) begin
      real_next = (ramp_up > {1'b0, target_next}) ? target_next : ramp_up[PWM_W-1:0];
    end else if (real_next > target_next) begin
      real_next = (real_next > STEP_V) ? real_next - STEP_V : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      sw_step    <= SWS_OFF;
      target_pwm <= '0;
      level_pwm  <= '0;
      real_pwm   <= '0;
      lost_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !fin_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_starting <= cmd.starting;
            r_remote   <= cmd.remote_mode;
            r_sw       <= cmd.switch_pos;
            r_buff     <= cmd.buff_hit;
            r_mouse    <= cmd.mouse_left;
            r_aim      <= cmd.auto_aim;
            r_klow     <= cmd.key_low;
            r_kmid     <= cmd.key_mid;
            r_seen     <= cmd.target_seen;
            r_sentry   <= cmd.aim_sentry;
            r_mag      <= cmd.magazine_open;
            neg        <= span_neg;
            span_mag_q <= span_mag;
            work       <= {{(PWM_W+1){1'b0}}, dist_off};
            cnt        <= '0;
            state      <= interp_req ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          work <= mul_next;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          work <= div_next;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            sw_step    <= sw_step_next;
            target_pwm <= target_next;
            level_pwm  <= level_next;
            real_pwm   <= real_next;
            lost_count <= lost_next;
            out_valid  <= 1'b1;
            out_pwm    <= real_next;
            out_target <= target_next;
            out_armed  <= target_next != '0;
            out_laser  <= (real_next != '0) && !r_buff && !r_mag;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.pwm_out      = out_pwm;
  assign rsp.beam_en      = out_laser;
  assign rsp.speed_target = out_target;
  assign rsp.wheel_armed  = out_armed;

  a_laser_needs_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_laser || out_pwm != '0))
    else $error("laser on with zero drive");

  a_armed_matches_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_armed == (out_target != '0)))
    else $error("armed flag disagrees with target");

  a_request_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL || state == S_FIN))
    else $error("accepted request not processed");

  a_mul_into_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && cnt == CNT_W'(MUL_STEPS - 1)) |=> (state == S_DIV && cnt == '0))
    else $error("multiply did not hand over to divide");

  a_result_held_until_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready && !fin_fire) |=> (out_valid && $stable(out_pwm)))
    else $error("pending result lost");

endmodule
`default_nettype wire
